@@ src/sv39w_pkg.sv @@
// Shared types and constants for the Sv39 page table walker.
package sv39w_pkg;

	localparam int unsigned PTE_PPN_SHIFT    = 10;
	localparam int unsigned PAGE_OFFSET_BITS = 12;
	localparam int unsigned VPN_BITS         = 9;
	localparam int unsigned ROOT_PPN_BITS    = 44;
	localparam int unsigned PAGING_ENABLE_BIT = 63;

	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_RESPONSE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_READ       = 2'd0,
		KIND_TRANSLATED = 2'd1,
		KIND_DIRECT     = 2'd2,
		KIND_FAIL       = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		LVL_IDLE = 2'd0,
		LVL_TOP  = 2'd1,
		LVL_MID  = 2'd2,
		LVL_LEAF = 2'd3
	} level_t;

	typedef struct packed {
		logic        produce;
		kind_t       kind;
		logic [63:0] addr;
	} step_res_t;

	function automatic logic [63:0] entry_base(input logic [63:0] pte);
		entry_base = (pte >> PTE_PPN_SHIFT) << PAGE_OFFSET_BITS;
	endfunction

	function automatic logic [63:0] vpn_offset(input logic [63:0] va, input logic [1:0] lvl);
		logic [VPN_BITS-1:0] vpn;
		vpn = VPN_BITS'(va >> (PAGE_OFFSET_BITS + VPN_BITS * 32'(lvl)));
		vpn_offset = 64'(vpn) << 3;
	endfunction

endpackage

@@ src/sv39_page_table_walker.sv @@
// Top level of the Sv39 page table walker: request register, walk logic, result register.
//
// Usage:
//   The input channel (in_valid/in_ready) carries two kinds of request: a translate
//   request (opcode 0, virtual_address) and a memory read response (opcode 1,
//   read_data). The output channel (out_valid/out_ready) returns result_kind and
//   address: a read request to memory, a translated address, a pass-through or a fail.
//   A translate with paging enabled yields three read requests, each answered by one
//   response request; the last response yields the translated address. The user writes
//   translation_control via cfg_we/cfg_wdata only while the block is idle (unenforced).
// Timing:
//   One request is accepted per cycle while in_ready is high. A result passes from the input
//   register to the result register, and the walk logic between them is one shift, one
//   64-bit add and a mux. Requests that produce no result drain in the same way without
//   occupying the output.
// Reset:
//   arst_n clears both registers' valid flags, the walk level and translation_control.
// Stall:
//   While out_ready is low the result holds; the input register still drains requests
//   that produce no result, and otherwise holds one request before in_ready drops.
module sv39_page_table_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [63:0] virtual_address,
	input  logic [63:0] read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [63:0] address,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import sv39w_pkg::*;

	logic        valid_s1;
	opcode_t     opcode_s1;
	logic [63:0] va_s1;
	logic [63:0] pte_s1;
	logic [63:0] ctl_q;
	logic        valid_s2;
	kind_t       kind_s2;
	logic [63:0] addr_s2;
	step_res_t   res;
	logic        walk_busy;
	logic        advance;
	logic        out_free;

	assign out_free  = !valid_s2 || out_ready;
	assign advance   = valid_s1 && (!res.produce || out_free);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (cfg_we) begin
			ctl_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= opcode_t'(opcode);
			va_s1     <= virtual_address;
			pte_s1    <= read_data;
		end
	end

	sv39w_step u_step (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (advance),
		.opcode              (opcode_s1),
		.virtual_address     (va_s1),
		.read_data           (pte_s1),
		.translation_control (ctl_q),
		.res                 (res),
		.walk_busy           (walk_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.produce) begin
			kind_s2 <= res.kind;
			addr_s2 <= res.addr;
		end
	end

	assign out_valid   = valid_s2;
	assign result_kind = kind_s2;
	assign address     = addr_s2;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_FAIL) |-> (addr_s2 == '0))
		else $error("fail result carries a nonzero address");

	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && walk_busy && opcode_s1 == OP_TRANSLATE) |-> (!res.produce && advance))
		else $error("translate during a walk was not dropped");

	a_idle_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !walk_busy && opcode_s1 == OP_RESPONSE) |-> !res.produce)
		else $error("response while idle produced a result");

	a_translated_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.produce && res.kind == KIND_TRANSLATED) |=> !walk_busy)
		else $error("walk still busy after translated result");

endmodule

@@ src/sv39w_step.sv @@
// Walk state and per-request translation logic of the Sv39 page table walker.
module sv39w_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  sv39w_pkg::opcode_t    opcode,
	input  logic [63:0]           virtual_address,
	input  logic [63:0]           read_data,
	input  logic [63:0]           translation_control,
	output sv39w_pkg::step_res_t  res,
	output logic                  walk_busy
);
	import sv39w_pkg::*;

	level_t      level_q;
	level_t      level_d;
	logic [63:0] saved_va_q;
	logic        save_va;
	logic [63:0] base;
	logic [63:0] root;
	logic [63:0] off_mask;

	assign walk_busy = (level_q != LVL_IDLE);
	assign base      = entry_base(read_data);
	assign root      = 64'(translation_control[ROOT_PPN_BITS-1:0]) << PAGE_OFFSET_BITS;
	assign off_mask  = (64'd1 << PAGE_OFFSET_BITS) - 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_IDLE;
		end else if (advance) begin
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && save_va) begin
			saved_va_q <= virtual_address;
		end
	end

	always_comb begin
		level_d     = level_q;
		save_va     = 1'b0;
		res.produce = 1'b0;
		res.kind    = KIND_READ;
		res.addr    = '0;
		if (opcode == OP_TRANSLATE) begin
			if (level_q == LVL_IDLE) begin
				res.produce = 1'b1;
				if (translation_control[PAGING_ENABLE_BIT]) begin
					save_va  = 1'b1;
					level_d  = LVL_TOP;
					res.kind = KIND_READ;
					res.addr = root + vpn_offset(virtual_address, 2'd2);
				end else if (translation_control != '0) begin
					res.kind = KIND_FAIL;
					res.addr = '0;
				end else begin
					res.kind = KIND_DIRECT;
					res.addr = virtual_address;
				end
			end
		end else begin
			unique case (level_q)
				LVL_IDLE: begin
					res.produce = 1'b0;
				end
				LVL_TOP: begin
					res.produce = 1'b1;
					level_d     = LVL_MID;
					res.kind    = KIND_READ;
					res.addr    = base + vpn_offset(saved_va_q, 2'd1);
				end
				LVL_MID: begin
					res.produce = 1'b1;
					level_d     = LVL_LEAF;
					res.kind    = KIND_READ;
					res.addr    = base + vpn_offset(saved_va_q, 2'd0);
				end
				LVL_LEAF: begin
					res.produce = 1'b1;
					level_d     = LVL_IDLE;
					res.kind    = KIND_TRANSLATED;
					res.addr    = base | (saved_va_q & off_mask);
				end
				default: begin
					level_d = LVL_IDLE;
				end
			endcase
		end
	end

endmodule
